// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the lock-key command capture RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising aclk edge out of reset.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising aclk edge out of reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/lkc_pkg.sv -----
// Types and constants for the lock-key command capture block.
package lkc_pkg;

    // Command state as reported on the result channel.
    typedef enum logic [1:0] {
        MODE_WAIT  = 2'd0,
        MODE_READY = 2'd1,
        MODE_PIN   = 2'd2
    } mode_t;

    // Request kinds carried on the input channel; the spare kind is ignored.
    localparam logic [1:0] REQ_LED   = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_SPARE = 2'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDLE_TIMEOUT    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PIN_PRESS_TOTAL = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CAPS_TAG        = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_NUM_TAG         = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCROLL_TAG      = 3'd4;

    // Register reset values.
    localparam logic [7:0] IDLE_TIMEOUT_RST    = 8'd50;
    localparam logic [7:0] PIN_PRESS_TOTAL_RST = 8'd8;
    localparam logic [1:0] CAPS_TAG_RST        = 2'd1;
    localparam logic [1:0] NUM_TAG_RST         = 2'd2;
    localparam logic [1:0] SCROLL_TAG_RST      = 2'd3;

    // LED byte layout.
    localparam int unsigned LED_NUM_BIT    = 0;
    localparam int unsigned LED_CAPS_BIT   = 1;
    localparam int unsigned LED_SCROLL_BIT = 2;
    localparam logic [7:0]  LAST_LEDS_RST  = 8'hFF;

    // Configuration register file.
    typedef struct packed {
        logic [7:0] idle_timeout;
        logic [7:0] pin_press_total;
        logic [1:0] caps_tag;
        logic [1:0] num_tag;
        logic [1:0] scroll_tag;
    } lkc_cfg_t;

    // Capture state carried from one word to the next.
    typedef struct packed {
        logic [7:0]  last_leds;
        logic [15:0] key_sequence;
        logic [7:0]  press_count;
        logic [7:0]  press_count_seen;
        logic [7:0]  idle_ticks;
        mode_t       mode;
        logic        led_seen;
    } lkc_state_t;

    localparam lkc_state_t STATE_RST = '{
        last_leds:        LAST_LEDS_RST,
        key_sequence:     16'd0,
        press_count:      8'd0,
        press_count_seen: 8'd0,
        idle_ticks:       8'd0,
        mode:             MODE_WAIT,
        led_seen:         1'b0
    };

endpackage

// ----- hdl/lkc_step.sv -----
// Next-state logic for one request word of the lock-key command capture.
module lkc_step
    import lkc_pkg::*;
(
    input  lkc_state_t cur,
    input  lkc_cfg_t   cfg,
    input  logic [1:0] req_type,
    input  logic [7:0] led_bits,
    input  logic       pin_present,
    output lkc_state_t nxt
);

    logic [7:0] led_diff;
    logic       press;
    logic [1:0] press_code;
    logic [8:0] idle_inc;
    logic       idle_expired;

    // First changed lock bit wins, caps before num before scroll.
    assign led_diff = cur.last_leds ^ led_bits;
    assign press    = led_diff[LED_CAPS_BIT] | led_diff[LED_NUM_BIT] | led_diff[LED_SCROLL_BIT];

    always_comb begin
        if (led_diff[LED_CAPS_BIT]) begin
            press_code = cfg.caps_tag;
        end else if (led_diff[LED_NUM_BIT]) begin
            press_code = cfg.num_tag;
        end else begin
            press_code = cfg.scroll_tag;
        end
    end

    // The idle compare is done one bit wider so a timeout of 255 still fires.
    assign idle_inc     = {1'b0, cur.idle_ticks} + 9'd1;
    assign idle_expired = idle_inc > {1'b0, cfg.idle_timeout};

    // State update for the request kind.
    always_comb begin
        nxt = cur;
        case (req_type)
            REQ_LED: begin
                if (press) begin
                    nxt.key_sequence = {cur.key_sequence[13:0], press_code};
                    nxt.press_count  = cur.press_count + 8'd1;
                end
                nxt.last_leds = led_bits;
                nxt.led_seen  = 1'b1;
            end
            REQ_TICK: begin
                if (cur.press_count != 8'd0) begin
                    if (cur.mode != MODE_WAIT) begin
                        // Presses outside the wait state are dropped.
                        nxt.press_count = 8'd0;
                    end else if (cur.press_count == cur.press_count_seen) begin
                        if (idle_expired) begin
                            if (pin_present) begin
                                nxt.mode = MODE_READY;
                            end else if (cur.press_count == cfg.pin_press_total) begin
                                nxt.mode = MODE_PIN;
                            end
                            nxt.press_count      = 8'd0;
                            nxt.press_count_seen = 8'd0;
                            nxt.idle_ticks       = 8'd0;
                        end else begin
                            nxt.idle_ticks = idle_inc[7:0];
                        end
                    end else begin
                        // A new press restarts the idle timer.
                        nxt.idle_ticks       = 8'd0;
                        nxt.press_count_seen = cur.press_count;
                    end
                end
            end
            REQ_CLEAR: begin
                nxt.key_sequence = 16'd0;
                nxt.mode         = MODE_WAIT;
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

endmodule

// ----- hdl/lock_key_command_capture.sv -----
// Top level of the lock-key command capture block.
//
//  Channel  Direction  Contents
//  s_       in         tuser[1:0] req_type; tdata[7:0] led_bits, [8] pin_present
//  m_       out        tdata[1:0] command_state, [17:2] command_sequence, [18] led_known
//  cfg_     in         write enable, 3-bit register index, 8-bit write data
//
// The capture state updates at the accepting edge and the result word is registered
// at the same edge, so one word per cycle is sustained while m_tready keeps up.
// The single output register sets the stall behavior: a new word is taken whenever
// the output register is empty or its word is being taken in the same cycle.
// Reset (aresetn low, synchronous) returns the configuration, the capture state and
// the result valid flag to their defaults; the result data register is not reset.
module lock_key_command_capture
    import lkc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [7:0] led_bits, [8] pin_present, rest zero
    input  logic [1:0]            s_tuser,   // [1:0] req_type
    // Result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // [1:0] command_state, [17:2] command_sequence,
                                             // [18] led_known, rest zero
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [7:0]            cfg_wdata
);

    `include "assert_macros.svh"

    lkc_cfg_t   cfg_reg;
    lkc_state_t st_reg;
    lkc_state_t st_next;
    logic       m_tvalid_reg;
    logic [23:0] m_tdata_reg;
    logic       s_accept;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.idle_timeout    <= IDLE_TIMEOUT_RST;
            cfg_reg.pin_press_total <= PIN_PRESS_TOTAL_RST;
            cfg_reg.caps_tag        <= CAPS_TAG_RST;
            cfg_reg.num_tag         <= NUM_TAG_RST;
            cfg_reg.scroll_tag      <= SCROLL_TAG_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_IDLE_TIMEOUT:    cfg_reg.idle_timeout    <= cfg_wdata;
                CFG_PIN_PRESS_TOTAL: cfg_reg.pin_press_total <= cfg_wdata;
                CFG_CAPS_TAG:        cfg_reg.caps_tag        <= cfg_wdata[1:0];
                CFG_NUM_TAG:         cfg_reg.num_tag         <= cfg_wdata[1:0];
                CFG_SCROLL_TAG:      cfg_reg.scroll_tag      <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Next capture state for the incoming word.
    lkc_step u_step (
        .cur         (st_reg),
        .cfg         (cfg_reg),
        .req_type    (s_tuser),
        .led_bits    (s_tdata[7:0]),
        .pin_present (s_tdata[8]),
        .nxt         (st_next)
    );

    // Capture state updates only on an accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= STATE_RST;
        end else if (s_accept) begin
            st_reg <= st_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Result word reflects the state after the update.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= {5'd0, st_next.led_seen, st_next.key_sequence, st_next.mode};
        end
    end

    `ASSERT_NEXT(a_accept_loads_result, s_accept, m_tvalid_reg,
        "accepted word did not produce a result")
    `ASSERT_NEXT(a_result_matches_mode, s_accept, m_tdata_reg[1:0] == st_reg.mode,
        "result state differs from stored mode")
    `ASSERT_NEXT(a_led_seen_sticky, st_reg.led_seen, st_reg.led_seen,
        "LED-known flag dropped without reset")
    `ASSERT_NEXT(a_mode_leaves_wait_on_tick,
        (st_reg.mode == MODE_WAIT) && !(s_accept && (s_tuser == REQ_TICK)),
        st_reg.mode == MODE_WAIT,
        "mode left wait state without a tick")
    `ASSERT_SAME(a_no_accept_when_full, m_tvalid_reg && !m_tready, !s_tready,
        "input taken while result word is stalled")

endmodule
